// ----- rtl/pwm_input_freq_duty_meter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// pwm input meter assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef PWM_INPUT_FREQ_DUTY_METER_UNIT_DEFINES_SVH
`define PWM_INPUT_FREQ_DUTY_METER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define PIFDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PIFDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pifdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwm input meter package
// shared widths, register indexes, per-slot entry and divider request types
// ----------------------------------------------------------------------------
package pifdm_pkg;

  localparam int NUM_TIMERS         = 3;
  localparam int CHANNELS_PER_TIMER = 6;
  localparam int NUM_SLOTS          = NUM_TIMERS * CHANNELS_PER_TIMER;
  localparam int SLOT_W             = $clog2(NUM_SLOTS);

  localparam int TIMER_W  = 2;
  localparam int CHAN_W   = 3;
  localparam int COUNT_W  = 16;
  localparam int CLOCK_W  = 27;
  localparam int PRESC_W  = 8;
  localparam int MASK_W   = 18;
  localparam int FREQ_W   = 27;
  localparam int PERIOD_W = 20;
  localparam int DUTY_W   = 14;
  localparam int TICKS_W  = PRESC_W + COUNT_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_ADDR_W-1:0] REG_CLOCK_HZ      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERTED_MASK = 2'd2;

  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd10000000;
  localparam logic [PRESC_W-1:0] PRESCALE_RESET = 8'h80;

  localparam logic           OP_CAPTURE = 1'b0;
  localparam logic           OP_TIMEOUT = 1'b1;

  localparam logic [DUTY_W-1:0]   FULL_DUTY  = 14'd10000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 20'hFFFFF;
  localparam int                  DUTY_SCALE = 1000;
  localparam int                  PERIOD_RND = 5;

  // divide by ten via reciprocal: floor(x * 0xCCCCCCCD / 2^35), exact below 2^32
  localparam int               RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCCCCCD;
  localparam int               RECIP_SHIFT = 35;
  localparam int               RND_W       = TICKS_W + 1;
  localparam int               PROD_W      = RND_W + RECIP_W;

  localparam int DIVIDEND_W = TICKS_W + 10;
  localparam int DIVISOR_W  = TICKS_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic                gated;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
    logic [DUTY_W-1:0]   duty;
  } entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

endpackage

// ----- rtl/pifdm_state_mem.sv -----
// ----------------------------------------------------------------------------
// pwm input meter slot state memory
// one entry per channel slot, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pifdm_state_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [pifdm_pkg::SLOT_W-1:0] waddr_i,
  input  pifdm_pkg::entry_t        wdata_i,
  input  logic                     re_i,
  input  logic [pifdm_pkg::SLOT_W-1:0] raddr_i,
  output pifdm_pkg::entry_t        rdata_o
);
  import pifdm_pkg::*;

  entry_t mem_q [NUM_SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pifdm_divider.sv -----
// ----------------------------------------------------------------------------
// pwm input meter serial divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pifdm_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pifdm_pkg::div_req_t              req_i,
  output logic                             done_o,
  output logic [pifdm_pkg::DIVIDEND_W-1:0] quotient_o
);
  import pifdm_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = DIVISOR_W'(trial - {1'b0, dvs_q});
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse after the last quotient bit is shifted in
      done_q <= !req_i.start && busy_q && (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/pwm_input_freq_duty_meter_unit.sv -----
// ----------------------------------------------------------------------------
// pwm input frequency and duty meter
// Takes capture and timeout events for 18 channel slots (3 timers of 6
// channels). A capture in period phase stores frequency = clock_hz / ticks
// and period = (ticks + 5) / 10, ticks = prescale * count; a capture in
// gated phase stores duty in 0.01 % units, clamped and optionally inverted.
// Each event returns one result with the slot's values after the event.
// A capture that divides runs from one request to the next through the slot
// read, 34 serial divider steps, the divider done, the slot update with the
// output register load and the idle state that takes the next request;
// timeouts, zero divisors and events for absent slots skip the divider. A
// result still waiting in the output register stalls the load, and no new
// request is taken until the load. Slot state sits in a small memory; per-slot
// valid bits are cleared by reset, so the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "pwm_input_freq_duty_meter_unit_defines.svh"

module pwm_input_freq_duty_meter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pifdm_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [pifdm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // timer_index, channel_index, capture_count, zero pad
  input  logic [pifdm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // frequency_hz, period_units, duty_hundredths, gated_mode, zero pad
  output logic [pifdm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // capture_stopped, divide_error
  output logic [pifdm_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
  import pifdm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [CLOCK_W-1:0] clock_hz_q;
  logic [PRESC_W-1:0] prescale_q;
  logic [MASK_W-1:0]  inv_mask_q;

  logic [TIMER_W-1:0] in_timer;
  logic [CHAN_W-1:0]  in_chan;
  logic [COUNT_W-1:0] in_count;
  logic               in_range;
  logic [SLOT_W-1:0]  in_slot;
  logic               accept;

  logic                op_q;
  logic                skip_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [TICKS_W-1:0]  ticks_q;
  logic [PROD_W-1:0]   per_prod_q;
  entry_t              ent_q, ent_d;
  logic                stopped_q, stopped_d;
  logic                derr_q, derr_d;
  logic                wr_q, wr_d;
  logic [NUM_SLOTS-1:0] valid_q;

  entry_t              mem_rdata;
  entry_t              cur;
  logic                mem_we;
  div_req_t            div_req;
  logic                div_done;
  logic [DIVIDEND_W-1:0] div_quot;

  logic [PROD_W-RECIP_SHIFT-1:0] per_raw;
  logic [PERIOD_W-1:0]           per_sat;
  logic [DUTY_W-1:0]             duty_clamp;
  logic [DUTY_W-1:0]             duty_new;
  logic                          out_load;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RESET;
      prescale_q <= PRESCALE_RESET;
      inv_mask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CLOCK_HZ:      clock_hz_q <= cfg_wdata_i[CLOCK_W-1:0];
        REG_PRESCALE:      prescale_q <= cfg_wdata_i[PRESC_W-1:0];
        REG_INVERTED_MASK: inv_mask_q <= cfg_wdata_i[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_timer = s_axis_tdata[TIMER_W-1:0];
  assign in_chan  = s_axis_tdata[TIMER_W+CHAN_W-1:TIMER_W];
  assign in_count = s_axis_tdata[TIMER_W+CHAN_W+COUNT_W-1:TIMER_W+CHAN_W];
  assign in_range = (int'(in_timer) < NUM_TIMERS) && (int'(in_chan) < CHANNELS_PER_TIMER);
  assign in_slot  = in_range ?
                    SLOT_W'(SLOT_W'(in_timer) * SLOT_W'(CHANNELS_PER_TIMER) + SLOT_W'(in_chan)) :
                    '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  pifdm_state_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (ent_q),
    .re_i    (accept),
    .raddr_i (in_slot),
    .rdata_o (mem_rdata)
  );

  // never-written slots read as the reset value
  assign cur = valid_q[slot_q] ? mem_rdata : '0;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIVIDEND_W'(clock_hz_q);
    div_req.divisor  = ticks_q;
    if (state_q == ST_READ && !skip_q && op_q == OP_CAPTURE) begin
      if (!cur.gated) begin
        div_req.start = (ticks_q != '0);
      end else begin
        div_req.start    = (cur.period != '0);
        div_req.dividend = DIVIDEND_W'(ticks_q) * DIVIDEND_W'(DUTY_SCALE);
        div_req.divisor  = DIVISOR_W'(cur.period);
      end
    end
  end

  pifdm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign per_raw    = per_prod_q[PROD_W-1:RECIP_SHIFT];
  assign per_sat    = (per_raw > (PROD_W-RECIP_SHIFT)'(PERIOD_MAX)) ?
                      PERIOD_MAX : per_raw[PERIOD_W-1:0];
  assign duty_clamp = (div_quot > DIVIDEND_W'(FULL_DUTY)) ? FULL_DUTY : div_quot[DUTY_W-1:0];
  assign duty_new   = inv_mask_q[slot_q] ? DUTY_W'(FULL_DUTY - duty_clamp) : duty_clamp;

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);
  assign mem_we   = out_load && wr_q;

  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    stopped_d = stopped_q;
    derr_d    = derr_q;
    wr_d      = wr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        stopped_d = 1'b0;
        derr_d    = 1'b0;
        wr_d      = 1'b0;
        ent_d     = cur;
        state_d   = ST_RESULT;
        if (skip_q) begin
          ent_d = '0;
        end else if (op_q == OP_TIMEOUT) begin
          ent_d     = '0;
          stopped_d = 1'b1;
          wr_d      = 1'b1;
        end else if (div_req.start) begin
          state_d = ST_DIV;
        end else begin
          derr_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr_d    = 1'b1;
          state_d = ST_RESULT;
          if (!ent_q.gated) begin
            ent_d.freq   = div_quot[FREQ_W-1:0];
            ent_d.period = per_sat;
            ent_d.gated  = 1'b1;
          end else begin
            ent_d.duty  = duty_new;
            ent_d.gated = 1'b0;
          end
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      skip_q  <= !in_range;
      slot_q  <= in_slot;
      ticks_q <= TICKS_W'(prescale_q) * TICKS_W'(in_count);
    end
    if (state_q == ST_READ) begin
      per_prod_q <= PROD_W'(RND_W'(ticks_q) + RND_W'(PERIOD_RND)) * PROD_W'(RECIP_TEN);
    end
    ent_q     <= ent_d;
    stopped_q <= stopped_d;
    derr_q    <= derr_d;
    wr_q      <= wr_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_DATA_W'({ent_q.gated, ent_q.duty, ent_q.period, ent_q.freq});
      out_user_q <= {derr_q, stopped_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `PIFDM_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_READ, "accepted request did not read")
  `PIFDM_ASSERT_NOW(a_div_done_state, div_done, state_q == ST_DIV, "divider done outside divide")
  `PIFDM_ASSERT_NOW(a_duty_range, m_axis_tvalid, m_axis_tdata[60:47] <= FULL_DUTY,
                    "duty above full scale")
  `PIFDM_ASSERT_NOW(a_write_in_result, mem_we, state_q == ST_RESULT && !stopped_q || wr_q,
                    "state write outside result")

endmodule

// ----- tb/tb_pwm_input_freq_duty_meter_unit.sv -----
// ----------------------------------------------------------------------------
// pwm input frequency and duty meter testbench
// Streams capture and timeout events into the meter and predicts every
// reading from its own model of the per-slot state. The sender runs in
// random bursts and the receiver stalls on its own pattern. Register
// settings change only while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pwm_input_freq_duty_meter_unit;
  import pifdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int END_SETTLE     = 60;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_EVENTS   = 220;
  localparam int OFF_PERIOD     = FREQ_W;
  localparam int OFF_DUTY       = FREQ_W + PERIOD_W;
  localparam int OFF_GATED      = FREQ_W + PERIOD_W + DUTY_W;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq;
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   duty;
    logic                gated;
    logic                stopped;
    logic                div_err;
  } reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // timer_index, channel_index, capture_count, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // opcode
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // frequency_hz, period_units, duty_hundredths, gated_mode, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // capture_stopped, divide_error
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // register copies and per-slot state of the meter model
  logic [CLOCK_W-1:0]  cfg_clock_hz;
  logic [PRESC_W-1:0]  cfg_prescale;
  logic [MASK_W-1:0]   cfg_inv_mask;
  logic                slot_gated  [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_period [NUM_SLOTS];
  logic [FREQ_W-1:0]   slot_freq   [NUM_SLOTS];
  logic [DUTY_W-1:0]   slot_duty   [NUM_SLOTS];
  logic [COUNT_W-1:0]  last_period_count [NUM_SLOTS];

  reading_t pending_readings[$];
  reading_t want_reading;
  reading_t got_reading;
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       rx_ready_left = 0;
  int       rx_stall_left = 0;

  pwm_input_freq_duty_meter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic reading_t predict_reading(input logic op, input logic [TIMER_W-1:0] tim,
                                               input logic [CHAN_W-1:0] ch,
                                               input logic [COUNT_W-1:0] cnt);
    reading_t    r;
    int unsigned slot;
    logic [63:0] ticks;
    logic [63:0] per;
    logic [63:0] duty;
    r = '0;
    if (tim >= NUM_TIMERS || ch >= CHANNELS_PER_TIMER) begin
      return r;
    end
    slot = tim * CHANNELS_PER_TIMER + ch;
    if (op == OP_TIMEOUT) begin
      slot_period[slot] = '0;
      slot_freq[slot]   = '0;
      slot_duty[slot]   = '0;
      slot_gated[slot]  = 1'b0;
      r.stopped = 1'b1;
    end else if (!slot_gated[slot]) begin
      ticks = 64'(cfg_prescale) * 64'(cnt);
      if (ticks == 0) begin
        r.div_err = 1'b1;
      end else begin
        per = (ticks + PERIOD_RND) / 10;
        if (per > PERIOD_MAX) per = PERIOD_MAX;
        slot_freq[slot]   = FREQ_W'(64'(cfg_clock_hz) / ticks);
        slot_period[slot] = PERIOD_W'(per);
        slot_gated[slot]  = 1'b1;
      end
    end else begin
      per = 64'(slot_period[slot]);
      if (per == 0) begin
        r.div_err = 1'b1;
      end else begin
        duty = 64'(cfg_prescale) * 64'(cnt) * 64'(DUTY_SCALE) / per;
        if (duty > FULL_DUTY) duty = FULL_DUTY;
        // slots past the mask width count as normal polarity
        if (slot < MASK_W && cfg_inv_mask[slot]) duty = FULL_DUTY - duty;
        slot_duty[slot]  = DUTY_W'(duty);
        slot_gated[slot] = 1'b0;
      end
    end
    r.freq   = slot_freq[slot];
    r.period = slot_period[slot];
    r.duty   = slot_duty[slot];
    r.gated  = slot_gated[slot];
    return r;
  endfunction

  // called and returns right after a falling edge
  task automatic send_event(input logic op, input logic [TIMER_W-1:0] tim,
                            input logic [CHAN_W-1:0] ch, input logic [COUNT_W-1:0] cnt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - TIMER_W - CHAN_W - COUNT_W){1'b0}}, cnt, ch, tim};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(op, tim, ch, cnt));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic release_bus();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drain();
    while (pending_readings.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      REG_CLOCK_HZ:      cfg_clock_hz = CLOCK_W'(data);
      REG_PRESCALE:      cfg_prescale = PRESC_W'(data);
      REG_INVERTED_MASK: cfg_inv_mask = MASK_W'(data);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [CLOCK_W-1:0] clock_hz,
                              input logic [PRESC_W-1:0] prescale, input logic [MASK_W-1:0] mask);
    release_bus();
    wait_drain();
    write_reg(REG_CLOCK_HZ, CFG_DATA_W'(clock_hz));
    write_reg(REG_PRESCALE, CFG_DATA_W'(prescale));
    write_reg(REG_INVERTED_MASK, CFG_DATA_W'(mask));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return COUNT_W'($urandom_range(1, 16));
      default: return COUNT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // reset register values, a full period then duty cycle, timeout and restart
  task automatic test_reset_state();
    send_event(OP_CAPTURE, 2'd0, 3'd0, 16'd1000);
    send_event(OP_CAPTURE, 2'd0, 3'd0, 16'd250);
    send_event(OP_CAPTURE, 2'd0, 3'd1, 16'd0);
    send_event(OP_CAPTURE, 2'd0, 3'd0, 16'd400);
    send_event(OP_TIMEOUT, 2'd0, 3'd0, 16'd400);
    send_event(OP_CAPTURE, 2'd0, 3'd0, 16'd1);
    // absent slots give an all-zero reading
    send_event(OP_CAPTURE, 2'd3, 3'd0, 16'd100);
    send_event(OP_TIMEOUT, 2'd0, 3'd6, 16'd0);
    send_event(OP_CAPTURE, 2'd2, 3'd7, 16'hFFFF);
  endtask

  // largest clock, unit prescale, every slot inverted
  task automatic test_extreme_config();
    apply_config(27'h7FFFFFF, 8'd1, 18'h3FFFF);
    // tiny tick count rounds the period to zero, then the duty divide fails
    send_event(OP_CAPTURE, 2'd2, 3'd5, 16'd3);
    send_event(OP_CAPTURE, 2'd2, 3'd5, 16'd100);
    send_event(OP_CAPTURE, 2'd2, 3'd4, 16'hFFFF);
    send_event(OP_CAPTURE, 2'd2, 3'd4, 16'hFFFF);
    send_event(OP_CAPTURE, 2'd0, 3'd5, 16'd1);
  endtask

  // largest prescale saturates the period, unit clock gives zero frequency
  task automatic test_saturation();
    apply_config(27'd1, 8'd255, 18'h2AAAA);
    send_event(OP_CAPTURE, 2'd1, 3'd0, 16'hFFFF);
    send_event(OP_CAPTURE, 2'd1, 3'd0, 16'd30000);
    send_event(OP_CAPTURE, 2'd1, 3'd1, 16'hFFFF);
    send_event(OP_CAPTURE, 2'd1, 3'd1, 16'd0);
  endtask

  task automatic test_zero_prescale();
    apply_config(CLOCK_HZ_RESET, 8'd0, 18'd0);
    send_event(OP_CAPTURE, 2'd1, 3'd2, 16'd500);
    send_event(OP_TIMEOUT, 2'd1, 3'd2, 16'd500);
  endtask

  task automatic test_random_traffic();
    logic                op;
    logic [TIMER_W-1:0]  tim;
    logic [CHAN_W-1:0]   ch;
    logic [COUNT_W-1:0]  cnt;
    int unsigned         slot;
    int unsigned         sel;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_config(CLOCK_HZ_RESET, PRESCALE_RESET, 18'd0);
        1: apply_config(27'd100000000, 8'd1, 18'h3FFFF);
        2: apply_config(CLOCK_W'($urandom_range(1, 100000000)), PRESC_W'($urandom_range(1, 128)),
                        MASK_W'($urandom));
        3: apply_config(27'h7FFFFFF, 8'd255, MASK_W'($urandom));
        4: apply_config(27'd1, PRESC_W'($urandom_range(0, 255)), 18'd0);
        default: apply_config(CLOCK_W'($urandom), PRESC_W'($urandom_range(1, 128)),
                              MASK_W'($urandom));
      endcase
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // hold the sender until every reading is back
        if (n == PHASE_EVENTS / 2 && (p == 0 || $urandom_range(0, 1) == 0)) begin
          release_bus();
          wait_drain();
        end
        sel = $urandom_range(0, 99);
        op  = (sel < 8) ? OP_TIMEOUT : OP_CAPTURE;
        if (sel >= 95) begin
          tim = ($urandom_range(0, 1) == 0) ? 2'd3 : TIMER_W'($urandom_range(0, 3));
          ch  = (tim == 2'd3) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(6, 7));
        end else begin
          tim = TIMER_W'($urandom_range(0, NUM_TIMERS - 1));
          ch  = CHAN_W'($urandom_range(0, CHANNELS_PER_TIMER - 1));
        end
        cnt = pick_count();
        if (tim < NUM_TIMERS && ch < CHANNELS_PER_TIMER && op == OP_CAPTURE) begin
          slot = tim * CHANNELS_PER_TIMER + ch;
          if (!slot_gated[slot]) begin
            last_period_count[slot] = cnt;
          end else if ($urandom_range(0, 9) < 7) begin
            // high time within the measured period
            cnt = COUNT_W'($urandom_range(0, last_period_count[slot]));
          end
        end
        send_event(op, tim, ch, cnt);
      end
    end
  endtask

  // receiver: ready stretches broken by stalls, some with no stall at all
  always @(negedge clk_i) begin
    if (rx_ready_left > 0) begin
      m_axis_tready <= 1'b1;
      rx_ready_left <= rx_ready_left - 1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_ready_left <= $urandom_range(0, 40);
      rx_stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_reading.freq    = m_axis_tdata[0 +: FREQ_W];
      got_reading.period  = m_axis_tdata[OFF_PERIOD +: PERIOD_W];
      got_reading.duty    = m_axis_tdata[OFF_DUTY +: DUTY_W];
      got_reading.gated   = m_axis_tdata[OFF_GATED];
      got_reading.stopped = m_axis_tuser[0];
      got_reading.div_err = m_axis_tuser[1];
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with no event pending, frequency", got_reading.freq, 0);
      end else begin
        want_reading = pending_readings.pop_front();
        if (got_reading.freq !== want_reading.freq)
          report_mismatch("frequency_hz", got_reading.freq, want_reading.freq);
        if (got_reading.period !== want_reading.period)
          report_mismatch("period_units", got_reading.period, want_reading.period);
        if (got_reading.duty !== want_reading.duty)
          report_mismatch("duty_hundredths", got_reading.duty, want_reading.duty);
        if (got_reading.gated !== want_reading.gated)
          report_mismatch("gated_mode", got_reading.gated, want_reading.gated);
        if (got_reading.stopped !== want_reading.stopped)
          report_mismatch("capture_stopped", got_reading.stopped, want_reading.stopped);
        if (got_reading.div_err !== want_reading.div_err)
          report_mismatch("divide_error", got_reading.div_err, want_reading.div_err);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_pwm_input_freq_duty_meter_unit failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    cfg_clock_hz = CLOCK_HZ_RESET;
    cfg_prescale = PRESCALE_RESET;
    cfg_inv_mask = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_gated[i]        = 1'b0;
      slot_period[i]       = '0;
      slot_freq[i]         = '0;
      slot_duty[i]         = '0;
      last_period_count[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_extreme_config();
    test_saturation();
    test_zero_prescale();
    test_random_traffic();

    release_bus();
    wait_drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      report_mismatch("readings never delivered", 0, pending_readings.size());
    end
    if (mismatch_count == 0) begin
      $display("tb_pwm_input_freq_duty_meter_unit passed");
    end else begin
      $display("tb_pwm_input_freq_duty_meter_unit failed");
    end
    $finish;
  end

endmodule
